// ===== rtl/bpru_pkg.sv =====
// Shared types, format codes and widening tables for the BMP pixel row unpacker.
`timescale 1ns / 1ps

package bpru_pkg;

    typedef enum logic [2:0] {
        FMT_1BPP  = 3'd0,
        FMT_4BPP  = 3'd1,
        FMT_8BPP  = 3'd2,
        FMT_16BPP = 3'd3,
        FMT_24BPP = 3'd4,
        FMT_32BPP = 3'd5
    } fmt_t;

    localparam logic REQ_DATA    = 1'b0;
    localparam logic REQ_PALETTE = 1'b1;

    // Configuration register indexes (byte address bit 2 selects)
    localparam logic REG_PIXEL_FORMAT = 1'b0;
    localparam logic REG_ROW_WIDTH    = 1'b1;

    localparam logic [2:0]  PIXEL_FORMAT_RESET = 3'd4;
    localparam logic [12:0] ROW_WIDTH_RESET    = 13'd1;

    typedef logic [31:0][7:0] lut5_t;
    typedef logic [63:0][7:0] lut6_t;

    function automatic lut5_t build_exp5();
        lut5_t t;
        for (int i = 0; i < 32; i++) begin
            t[i] = 8'((i * 255) / 31);
        end
        return t;
    endfunction

    function automatic lut6_t build_exp6();
        lut6_t t;
        for (int i = 0; i < 64; i++) begin
            t[i] = 8'((i * 255) / 63);
        end
        return t;
    endfunction

    localparam lut5_t EXP5_LUT = build_exp5();
    localparam lut6_t EXP6_LUT = build_exp6();

    // One unit of work handed from the row decoder to the pixel issue stage
    typedef struct packed {
        logic        wr;       // palette entry write
        logic        pal;      // pixels are palette indices
        fmt_t        fmt;
        logic [7:0]  data;     // raw byte for index extraction
        logic [2:0]  last;     // index of the last pixel of this item
        logic        row_end;  // last pixel closes the row
        logic [7:0]  idx;      // palette entry to write
        logic [23:0] rgb;      // direct color, or palette write data
    } job_t;

endpackage

// ===== rtl/bpru_row_decode.sv =====
// Row position tracking and per-byte pixel job formation.
`timescale 1ns / 1ps

module bpru_row_decode #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic              req_type,
    input  logic [7:0]        data_byte,
    input  logic [7:0]        pal_index,
    input  logic [7:0]        pal_red,
    input  logic [7:0]        pal_green,
    input  logic [7:0]        pal_blue,
    input  logic [2:0]        pixel_format,
    input  logic [12:0]       row_width,
    input  logic              cfg_clear,
    output logic              job_load,
    output bpru_pkg::job_t    job
);

    localparam int PW = $clog2(MAX_WIDTH + 1);
    localparam int CW = PW + 4;
    localparam int RW = PW + 3;

    logic [PW-1:0] pix_reg,   pix_next;
    logic [RW-1:0] byte_reg,  byte_next;
    logic [1:0]    phase_reg, phase_next;
    logic [23:0]   part_reg,  part_next;

    bpru_pkg::fmt_t fmt;
    logic [PW-1:0]  w;
    logic [RW-1:0]  wr_w;
    logic [RW-1:0]  rb;
    logic [PW-1:0]  remaining;
    logic [3:0]     n;
    logic [23:0]    merged;
    logic [1:0]     last_phase;
    logic [CW-1:0]  pix_sum;

    always_comb begin
        case (pixel_format)
            bpru_pkg::FMT_1BPP:  fmt = bpru_pkg::FMT_1BPP;
            bpru_pkg::FMT_4BPP:  fmt = bpru_pkg::FMT_4BPP;
            bpru_pkg::FMT_8BPP:  fmt = bpru_pkg::FMT_8BPP;
            bpru_pkg::FMT_16BPP: fmt = bpru_pkg::FMT_16BPP;
            bpru_pkg::FMT_32BPP: fmt = bpru_pkg::FMT_32BPP;
            default:             fmt = bpru_pkg::FMT_24BPP;
        endcase

        if (row_width == 13'd0) begin
            w = PW'(1);
        end else if (32'(row_width) > 32'(MAX_WIDTH)) begin
            w = PW'(MAX_WIDTH);
        end else begin
            w = PW'(row_width);
        end
        wr_w = RW'(w);

        // Bytes per padded row
        case (fmt)
            bpru_pkg::FMT_1BPP:  rb = (((wr_w + RW'(7)) >> 3) + RW'(3)) & ~RW'(3);
            bpru_pkg::FMT_4BPP:  rb = (((wr_w + RW'(1)) >> 1) + RW'(3)) & ~RW'(3);
            bpru_pkg::FMT_8BPP:  rb = (wr_w + RW'(3)) & ~RW'(3);
            bpru_pkg::FMT_16BPP: rb = ((wr_w << 1) + RW'(3)) & ~RW'(3);
            bpru_pkg::FMT_32BPP: rb = wr_w << 2;
            default:             rb = ((wr_w << 1) + wr_w + RW'(3)) & ~RW'(3);
        endcase
    end

    always_comb begin
        pix_next   = pix_reg;
        byte_next  = byte_reg;
        phase_next = phase_reg;
        part_next  = part_reg;
        n          = 4'd0;
        remaining  = w - pix_reg;
        last_phase = (fmt == bpru_pkg::FMT_32BPP) ? 2'd3 : 2'd2;
        merged     = part_reg;
        pix_sum    = CW'(pix_reg);

        job         = '0;
        job.wr      = (req_type == bpru_pkg::REQ_PALETTE);
        job.fmt     = fmt;
        job.data    = data_byte;
        job.idx     = pal_index;
        job.pal     = (fmt == bpru_pkg::FMT_1BPP) || (fmt == bpru_pkg::FMT_4BPP) ||
                      (fmt == bpru_pkg::FMT_8BPP);

        case (phase_reg)
            2'd0:    merged = part_reg | {16'd0, data_byte};
            2'd1:    merged = part_reg | {8'd0, data_byte, 8'd0};
            2'd2:    merged = part_reg | {data_byte, 16'd0};
            default: merged = part_reg;
        endcase

        if (req_type == bpru_pkg::REQ_PALETTE) begin
            job.rgb = {pal_red, pal_green, pal_blue};
        end else begin
            byte_next = byte_reg + RW'(1);
            if (pix_reg < w) begin
                case (fmt)
                    bpru_pkg::FMT_1BPP: begin
                        n = (CW'(remaining) >= CW'(8)) ? 4'd8 : 4'(remaining);
                    end
                    bpru_pkg::FMT_4BPP: begin
                        n = (CW'(remaining) >= CW'(2)) ? 4'd2 : 4'd1;
                    end
                    bpru_pkg::FMT_8BPP: begin
                        n = 4'd1;
                    end
                    bpru_pkg::FMT_16BPP: begin
                        if (phase_reg == 2'd0) begin
                            part_next  = {16'd0, data_byte};
                            phase_next = 2'd1;
                        end else begin
                            n          = 4'd1;
                            job.rgb    = {bpru_pkg::EXP5_LUT[data_byte[7:3]],
                                          bpru_pkg::EXP6_LUT[{data_byte[2:0], part_reg[7:5]}],
                                          bpru_pkg::EXP5_LUT[part_reg[4:0]]};
                            phase_next = 2'd0;
                            part_next  = '0;
                        end
                    end
                    default: begin
                        if (phase_reg >= last_phase) begin
                            n          = 4'd1;
                            job.rgb    = merged;
                            phase_next = 2'd0;
                            part_next  = '0;
                        end else begin
                            phase_next = phase_reg + 2'd1;
                            part_next  = merged;
                        end
                    end
                endcase
            end
            pix_sum  = CW'(pix_reg) + CW'(n);
            pix_next = PW'(pix_sum);
            if (byte_next >= rb) begin
                pix_next   = '0;
                byte_next  = '0;
                phase_next = 2'd0;
                part_next  = '0;
            end
        end

        job.last    = 3'(n - 4'd1);
        job.row_end = (pix_sum == CW'(w));
        job_load    = accept && (job.wr || (n != 4'd0));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_clear) begin
            pix_reg   <= '0;
            byte_reg  <= '0;
            phase_reg <= 2'd0;
            part_reg  <= '0;
        end else if (accept) begin
            pix_reg   <= pix_next;
            byte_reg  <= byte_next;
            phase_reg <= phase_next;
            part_reg  <= part_next;
        end
    end

endmodule

// ===== rtl/bpru_pixel_issue.sv =====
// Job sequencer, palette memory with read stage, and output register.
`timescale 1ns / 1ps

module bpru_pixel_issue #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              job_load,
    input  bpru_pkg::job_t    job_in,
    output logic              job_free,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_red,
    output logic [7:0]        m_green,
    output logic [7:0]        m_blue,
    output logic              m_row_end,
    output logic              m_run_last
);

    localparam int AW = $clog2(PALETTE_DEPTH);

    bpru_pkg::job_t job_reg;
    logic           job_valid_reg, job_valid_next;
    logic [2:0]     k_reg, k_next;

    logic [23:0]    mem [PALETTE_DEPTH];
    logic [23:0]    rdata_reg;

    logic           r_valid_reg, r_valid_next;
    logic           r_pal_reg, r_zero_reg, r_row_end_reg, r_last_reg;
    logic [23:0]    r_rgb_reg;

    logic           m_valid_reg, m_valid_next;
    logic [23:0]    m_rgb_reg;
    logic           m_row_end_reg, m_run_last_reg;

    logic           out_free, adv, issue, is_last, job_done;
    logic           rd_en, wr_en;
    logic [7:0]     pix_idx;
    logic [23:0]    r_color;

    always_comb begin
        out_free = !m_valid_reg || m_ready;
        adv      = !r_valid_reg || out_free;
        issue    = job_valid_reg && adv;
        is_last  = (k_reg == job_reg.last);
        job_done = issue && (job_reg.wr || is_last);
        job_free = !job_valid_reg || job_done;

        case (job_reg.fmt)
            bpru_pkg::FMT_1BPP: pix_idx = {7'd0, job_reg.data[3'd7 - k_reg]};
            bpru_pkg::FMT_4BPP: pix_idx = k_reg[0] ? {4'd0, job_reg.data[3:0]}
                                                   : {4'd0, job_reg.data[7:4]};
            default:            pix_idx = job_reg.data;
        endcase

        wr_en = issue && job_reg.wr && ({1'b0, job_reg.idx} < 9'(PALETTE_DEPTH));
        rd_en = issue && !job_reg.wr && job_reg.pal;

        job_valid_next = job_load ? 1'b1 : (job_done ? 1'b0 : job_valid_reg);
        k_next         = (job_load || job_done) ? 3'd0 : (issue ? k_reg + 3'd1 : k_reg);

        r_valid_next = (issue && !job_reg.wr) ? 1'b1 : (out_free ? 1'b0 : r_valid_reg);
        m_valid_next = out_free ? r_valid_reg : m_valid_reg;

        if (!r_pal_reg) begin
            r_color = r_rgb_reg;
        end else if (r_zero_reg) begin
            r_color = '0;
        end else begin
            r_color = rdata_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            k_reg         <= 3'd0;
            r_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            job_valid_reg <= job_valid_next;
            k_reg         <= k_next;
            r_valid_reg   <= r_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Palette memory: one write or one read per cycle, read data registered
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[job_reg.idx[AW-1:0]] <= job_reg.rgb;
        end
        if (rd_en) begin
            rdata_reg <= mem[pix_idx[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (job_load) begin
            job_reg <= job_in;
        end
        if (issue && !job_reg.wr) begin
            r_pal_reg     <= job_reg.pal;
            r_zero_reg    <= ({1'b0, pix_idx} >= 9'(PALETTE_DEPTH));
            r_rgb_reg     <= job_reg.rgb;
            r_row_end_reg <= job_reg.row_end && is_last;
            r_last_reg    <= is_last;
        end
        if (out_free && r_valid_reg) begin
            m_rgb_reg      <= r_color;
            m_row_end_reg  <= r_row_end_reg;
            m_run_last_reg <= r_last_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_red      = m_rgb_reg[23:16];
    assign m_green    = m_rgb_reg[15:8];
    assign m_blue     = m_rgb_reg[7:0];
    assign m_row_end  = m_row_end_reg;
    assign m_run_last = m_run_last_reg;

endmodule

// ===== rtl/bmp_pixel_row_unpacker_top.sv =====
// Top level of the BMP pixel row unpacker: config port, row decoder and pixel issue.
`timescale 1ns / 1ps
//
// Usage:
//   s_* channel takes one item per handshake: either a raw pixel-array byte
//   (req_type 0) or a palette entry write (req_type 1). m_* channel gives one
//   decoded 8-bit RGB pixel per handshake, with row_end on the last pixel of a
//   row and run_last on the last pixel produced by one input byte.
//   The config port sets pixel_format (0x0) and row_width (0x4); any write
//   returns the row position to its start and keeps the palette.
// Path: each pixel passes the job register, the read stage and the output register.
// Throughput: one pixel per cycle when not stalled, set by the single palette
//   memory port; a byte producing k pixels (k up to 8 at 1bpp, 2 at 4bpp) or a
//   palette write holds the input until it is fully issued. Bytes giving no pixel
//   (padding, partial 16/24/32-bit pixels) are taken every cycle the slot is free.
// Reset: synchronous, active low; clears row position and pipeline, sets
//   24bpp and a row width of one. Palette contents are undefined until written.
// Stall: when m_ready is low the output and read stages hold and the input
//   backs up through s_ready; nothing is dropped.
//
module bmp_pixel_row_unpacker_top #(
    parameter int MAX_WIDTH     = 4096,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [7:0]  s_data_byte,
    input  logic [7:0]  s_pal_index,
    input  logic [7:0]  s_pal_red,
    input  logic [7:0]  s_pal_green,
    input  logic [7:0]  s_pal_blue,
    // pixel items
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue,
    output logic        m_row_end,
    output logic        m_run_last
);

    logic [2:0]     pixel_format_reg;
    logic [12:0]    row_width_reg;
    logic           cfg_wr;
    logic           accept;
    logic           job_load;
    logic           job_free;
    bpru_pkg::job_t job;

    // Register write completes in the access phase; pready never stalls
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == bpru_pkg::REG_ROW_WIDTH) ? {19'd0, row_width_reg}
                                                          : {29'd0, pixel_format_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_format_reg <= bpru_pkg::PIXEL_FORMAT_RESET;
            row_width_reg    <= bpru_pkg::ROW_WIDTH_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == bpru_pkg::REG_PIXEL_FORMAT) begin
                pixel_format_reg <= pwdata[2:0];
            end else begin
                row_width_reg <= pwdata[12:0];
            end
        end
    end

    // Take the next item whenever the job slot is empty or drains this cycle
    assign s_ready = job_free;
    assign accept  = s_valid && s_ready;

    bpru_row_decode #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_decode (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .req_type     (s_req_type),
        .data_byte    (s_data_byte),
        .pal_index    (s_pal_index),
        .pal_red      (s_pal_red),
        .pal_green    (s_pal_green),
        .pal_blue     (s_pal_blue),
        .pixel_format (pixel_format_reg),
        .row_width    (row_width_reg),
        .cfg_clear    (cfg_wr),
        .job_load     (job_load),
        .job          (job)
    );

    bpru_pixel_issue #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_issue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .job_load   (job_load),
        .job_in     (job),
        .job_free   (job_free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_red      (m_red),
        .m_green    (m_green),
        .m_blue     (m_blue),
        .m_row_end  (m_row_end),
        .m_run_last (m_run_last)
    );

endmodule

// ===== tb/sv/bmp_pixel_row_unpacker_top_tb.sv =====
// Self-checking testbench for the BMP pixel row unpacker: palette, all formats, row padding.
`timescale 1ns / 1ps

module bmp_pixel_row_unpacker_top_tb;

    // Widest row the block handles; larger register values saturate to it
    localparam int MAX_PIXELS = 4096;
    // Format code with no format of its own: decodes as 24bpp
    localparam logic [2:0] FMT_SPARE7 = 3'd7;
    // Cycles to let a palette write or padding byte clear the pipeline
    localparam int SETTLE_CYCLES = 8;
    // Bound on any wait for outstanding pixels
    localparam int DRAIN_LIMIT = 20000;
    // Palette entries loaded up front; 8bpp indices stay below this
    localparam int LOADED_ENTRIES = 32;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       row_end;
        logic       run_last;
    } pixel_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic        s_req_type;
    logic [7:0]  s_data_byte;
    logic [7:0]  s_pal_index;
    logic [7:0]  s_pal_red;
    logic [7:0]  s_pal_green;
    logic [7:0]  s_pal_blue;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_red;
    logic [7:0]  m_green;
    logic [7:0]  m_blue;
    logic        m_row_end;
    logic        m_run_last;

    // Shadow of the block: palette, registers and row position
    logic [23:0] palette_mem [256];
    logic [2:0]  format_reg;
    logic [12:0] width_reg;
    int          pix_pos;
    int          byte_pos;
    int          byte_phase;
    logic [23:0] partial_rgb;
    pixel_t      expected_pixels [$];

    int src_idle_pct;
    int sink_idle_pct;
    int errors;
    int items_sent;
    int items_taken;
    int palette_writes;
    int pixels_checked;
    int reg_writes;

    bmp_pixel_row_unpacker_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_data_byte (s_data_byte),
        .s_pal_index (s_pal_index),
        .s_pal_red   (s_pal_red),
        .s_pal_green (s_pal_green),
        .s_pal_blue  (s_pal_blue),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red       (m_red),
        .m_green     (m_green),
        .m_blue      (m_blue),
        .m_row_end   (m_row_end),
        .m_run_last  (m_run_last)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Pixel prediction
    // ---------------------------------------------------------------------

    // Spare format codes fall back to 24bpp
    function automatic bpru_pkg::fmt_t active_format();
        return (format_reg > 3'd5) ? bpru_pkg::FMT_24BPP : bpru_pkg::fmt_t'(format_reg);
    endfunction

    // Zero width acts as one; oversize widths clamp to the maximum
    function automatic int active_width();
        if (width_reg == 13'd0) return 1;
        if (width_reg > MAX_PIXELS) return MAX_PIXELS;
        return int'(width_reg);
    endfunction

    // Bytes in one stored row, padded to a 4-byte boundary (32bpp rows never need it)
    function automatic int padded_row_bytes(input bpru_pkg::fmt_t f, input int w);
        int raw;
        case (f)
            bpru_pkg::FMT_1BPP:  raw = (w + 7) / 8;
            bpru_pkg::FMT_4BPP:  raw = (w + 1) / 2;
            bpru_pkg::FMT_8BPP:  raw = w;
            bpru_pkg::FMT_16BPP: raw = 2 * w;
            bpru_pkg::FMT_32BPP: return 4 * w;
            default:             raw = 3 * w;
        endcase
        return (raw + 3) / 4 * 4;
    endfunction

    // Scale a 5- or 6-bit channel to 8 bits, truncating
    function automatic logic [7:0] widen(input int x, input int top);
        return 8'((x * 255) / top);
    endfunction

    // Random raw byte; at 8bpp keep the index inside the loaded part of the palette
    function automatic logic [7:0] random_byte();
        logic [7:0] d;
        d = 8'($urandom);
        if (active_format() == bpru_pkg::FMT_8BPP) d = d & 8'(LOADED_ENTRIES - 1);
        return d;
    endfunction

    function automatic void clear_row_position();
        pix_pos     = 0;
        byte_pos    = 0;
        byte_phase  = 0;
        partial_rgb = '0;
    endfunction

    // Build one pixel at the current row position and advance it
    function automatic pixel_t make_pixel(input logic [23:0] rgb, input int w);
        pixel_t p;
        p.red      = rgb[23:16];
        p.green    = rgb[15:8];
        p.blue     = rgb[7:0];
        p.row_end  = (pix_pos + 1 == w);
        p.run_last = 1'b0;
        pix_pos++;
        return p;
    endfunction

    // Expand one raw byte into the pixels it completes and queue them
    function automatic void decode_byte(input logic [7:0] d);
        bpru_pkg::fmt_t f;
        int             w;
        int             n;
        int             k;
        int             last_phase;
        logic [15:0]    word;
        pixel_t         run [8];
        f = active_format();
        w = active_width();
        n = 0;
        if (pix_pos < w) begin
            case (f)
                bpru_pkg::FMT_1BPP: begin
                    for (k = 0; k < 8 && pix_pos < w; k++) begin
                        run[n] = make_pixel(palette_mem[8'(d[7 - k])], w);
                        n++;
                    end
                end
                bpru_pkg::FMT_4BPP: begin
                    run[n] = make_pixel(palette_mem[8'(d[7:4])], w);
                    n++;
                    if (pix_pos < w) begin
                        run[n] = make_pixel(palette_mem[8'(d[3:0])], w);
                        n++;
                    end
                end
                bpru_pkg::FMT_8BPP: begin
                    run[n] = make_pixel(palette_mem[d], w);
                    n++;
                end
                bpru_pkg::FMT_16BPP: begin
                    if (byte_phase == 0) begin
                        partial_rgb = 24'(d);
                        byte_phase  = 1;
                    end else begin
                        word   = {d, partial_rgb[7:0]};
                        run[n] = make_pixel({widen(word[15:11], 31), widen(word[10:5], 63),
                                             widen(word[4:0], 31)}, w);
                        n++;
                        byte_phase  = 0;
                        partial_rgb = '0;
                    end
                end
                default: begin
                    // Bytes come blue, green, red; a 32bpp pixel adds an unused fourth byte
                    last_phase = (f == bpru_pkg::FMT_32BPP) ? 3 : 2;
                    if (byte_phase < 3) partial_rgb = partial_rgb | (24'(d) << (8 * byte_phase));
                    if (byte_phase >= last_phase) begin
                        run[n] = make_pixel(partial_rgb, w);
                        n++;
                        byte_phase  = 0;
                        partial_rgb = '0;
                    end else begin
                        byte_phase++;
                    end
                end
            endcase
        end
        for (k = 0; k < n; k++) begin
            if (k == n - 1) run[k].run_last = 1'b1;
            expected_pixels.push_back(run[k]);
        end
        byte_pos++;
        if (byte_pos >= padded_row_bytes(f, w)) clear_row_position();
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // ---------------------------------------------------------------------
    // Monitor: predict on each taken item, compare each pixel item
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        pixel_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                items_taken++;
                if (s_req_type == bpru_pkg::REQ_PALETTE) begin
                    palette_mem[s_pal_index] = {s_pal_red, s_pal_green, s_pal_blue};
                    palette_writes++;
                end else begin
                    decode_byte(s_data_byte);
                end
            end
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("pixel with no expectation: red %0d green %0d blue %0d",
                           m_red, m_green, m_blue);
                    errors++;
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("red", want.red, m_red);
                    check_field("green", want.green, m_green);
                    check_field("blue", want.blue, m_blue);
                    check_field("row_end", 8'(want.row_end), 8'(m_row_end));
                    check_field("run_last", 8'(want.run_last), 8'(m_run_last));
                    pixels_checked++;
                end
            end
        end
    end

    // Receiver: stall at random for the current share of cycles
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    // Offer one item, idling first at random; hold it until taken
    task automatic send_item(input logic kind, input logic [7:0] data, input logic [7:0] idx,
                             input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_req_type  <= kind;
        s_data_byte <= data;
        s_pal_index <= idx;
        s_pal_red   <= r;
        s_pal_green <= g;
        s_pal_blue  <= b;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Unused fields carry noise so the block must ignore them
    task automatic send_data(input logic [7:0] data);
        send_item(bpru_pkg::REQ_DATA, data, 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom));
    endtask

    task automatic send_palette(input logic [7:0] idx, input logic [23:0] rgb);
        send_item(bpru_pkg::REQ_PALETTE, 8'($urandom), idx, rgb[23:16], rgb[15:8], rgb[7:0]);
    endtask

    // Drop valid and wait until every predicted pixel is out and the pipeline is empty
    task automatic drain_pixels();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One APB write: setup cycle, then access cycle; psel is released by the caller
    task automatic reg_write(input logic which, input logic [12:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (which == bpru_pkg::REG_PIXEL_FORMAT) format_reg = value[2:0];
        else width_reg = value;
        clear_row_position();
        reg_writes++;
    endtask

    // Reprogram both registers once the block is idle
    task automatic configure(input logic [2:0] f, input logic [12:0] w);
        drain_pixels();
        reg_write(bpru_pkg::REG_PIXEL_FORMAT, 13'(f));
        reg_write(bpru_pkg::REG_ROW_WIDTH, w);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Load the low palette entries; every pixel index the tests produce falls in them
    task automatic test_palette_load();
        int i;
        for (i = 0; i < LOADED_ENTRIES; i++) begin
            if (i == 0) send_palette(8'(i), 24'h000000);
            else if (i == LOADED_ENTRIES - 1) send_palette(8'(i), 24'hFFFFFF);
            else send_palette(8'(i), 24'($urandom));
        end
    endtask

    // Out of reset: 24bpp, one pixel per row, three color bytes plus one pad byte
    task automatic test_reset_defaults();
        send_data(8'h00);
        send_data(8'hFF);
        send_data(8'h80);
        send_data(8'h5A);
    endtask

    task automatic test_each_format();
        // 1bpp, three pixels: spare low bits and three pad bytes give nothing
        configure(bpru_pkg::FMT_1BPP, 13'd3);
        send_data(8'hA5);
        repeat (3) send_data(8'($urandom));
        // 4bpp, three pixels: low nibble of the second byte is spare
        configure(bpru_pkg::FMT_4BPP, 13'd3);
        send_data(8'h0F);
        send_data(8'hF0);
        repeat (2) send_data(8'($urandom));
        // 8bpp with a zero width register: acts as one pixel per row
        configure(bpru_pkg::FMT_8BPP, 13'd0);
        send_data(8'(LOADED_ENTRIES - 1));
        repeat (3) send_data(8'($urandom));
        // RGB565: full white then pure green
        configure(bpru_pkg::FMT_16BPP, 13'd2);
        send_data(8'hFF);
        send_data(8'hFF);
        send_data(8'hE0);
        send_data(8'h07);
    endtask

    task automatic test_special_cases();
        // Oversize width saturates; the row stays open after one 32bpp pixel
        configure(bpru_pkg::FMT_32BPP, 13'h1FFF);
        send_data(8'h11);
        send_data(8'h22);
        send_data(8'h33);
        send_data(8'h44);
        // Spare format code decodes as 24bpp; a palette write mid-pixel keeps the position
        configure(FMT_SPARE7, 13'd1);
        send_data(8'h01);
        send_palette(8'($urandom), 24'($urandom));
        send_data(8'h02);
        send_data(8'h03);
        send_data(8'($urandom));
    endtask

    // Whole rows under random settings, with palette rewrites and cut-off rows mixed in
    task automatic test_random_rows(input int budget);
        int          stop_at;
        int          pick;
        int          rows;
        int          nbytes;
        int          cut;
        int          r;
        int          b;
        logic [2:0]  f;
        logic [12:0] w;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 19);
            f = (pick < 18) ? 3'(pick % 6) : 3'(pick - 12);
            pick = $urandom_range(0, 19);
            if (pick < 15) w = 13'($urandom_range(1, 12));
            else if (pick < 18) w = 13'($urandom_range(13, 64));
            else if (pick == 18) w = 13'd0;
            else if ($urandom_range(0, 1) == 0) w = 13'(MAX_PIXELS);
            else w = 13'($urandom_range(MAX_PIXELS + 1, 8191));
            configure(f, w);
            nbytes = padded_row_bytes(active_format(), active_width());
            rows   = $urandom_range(1, 3);
            // Widest rows: send only the start, the next setting cuts them off
            if (active_width() == MAX_PIXELS) begin
                rows   = 1;
                nbytes = $urandom_range(1, 24);
            end
            // Stop mid-row once the budget is spent; the next setting restarts the row
            for (r = 0; r < rows && items_sent < stop_at; r++) begin
                cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, nbytes) : nbytes;
                for (b = 0; b < cut && items_sent < stop_at; b++) begin
                    if ($urandom_range(0, 9) == 0) send_palette(8'($urandom), 24'($urandom));
                    send_data(random_byte());
                end
                if (cut < nbytes) break;
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------
    initial begin
        aresetn     <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        s_valid     <= 1'b0;
        s_req_type  <= bpru_pkg::REQ_DATA;
        s_data_byte <= '0;
        s_pal_index <= '0;
        s_pal_red   <= '0;
        s_pal_green <= '0;
        s_pal_blue  <= '0;
        format_reg  = bpru_pkg::PIXEL_FORMAT_RESET;
        width_reg   = bpru_pkg::ROW_WIDTH_RESET;
        clear_row_position();

        // Sender idles little, receiver stalls a lot
        src_idle_pct  = 25;
        sink_idle_pct = 65;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_palette_load();
        test_reset_defaults();
        test_each_format();
        test_special_cases();
        test_random_rows(97);

        // Swap: sender idles a lot, receiver stalls little
        drain_pixels();
        src_idle_pct  = 65;
        sink_idle_pct = 25;
        test_random_rows(97);

        // Full rate on both sides
        drain_pixels();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_rows(96);

        drain_pixels();
        if (expected_pixels.size() != 0) begin
            $error("%0d predicted pixels never arrived", expected_pixels.size());
            errors++;
        end
        $display("Covered %0d input items (%0d palette writes), %0d pixels, %0d register writes.",
                 items_taken, palette_writes, pixels_checked, reg_writes);
        $display("All six formats and spare codes, zero and oversize widths, three idle mixes.");
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Hard stop if the block hangs
    initial begin
        #20_000_000;
        $display("Timed out waiting on the block");
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bpru_pkg.sv
rtl/bpru_row_decode.sv
rtl/bpru_pixel_issue.sv
rtl/bmp_pixel_row_unpacker_top.sv
tb/sv/bmp_pixel_row_unpacker_top_tb.sv
